### rtl/krq_pkg.sv
// ----------------------------------------------------------------------------
// krq_pkg
// Shared types and constants for the keyed thread ready queue.
// ----------------------------------------------------------------------------
package krq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    addr_t  rd_addr;
  } store_req_t;

  typedef struct packed {
    status_t status;
    key_t    key;
    handle_t handle;
    cnt_t    count;
  } result_t;

endpackage

### rtl/krq_if.sv
// ----------------------------------------------------------------------------
// krq_in_if / krq_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface krq_in_if;
  logic              valid;
  logic              ready;
  krq_pkg::cmd_t     command;
  krq_pkg::key_t     thread_key;
  krq_pkg::handle_t  thread_handle;

  modport source (output valid, output command, output thread_key,
                  output thread_handle, input ready);
  modport sink   (input valid, input command, input thread_key,
                  input thread_handle, output ready);
endinterface

interface krq_out_if;
  logic              valid;
  logic              ready;
  krq_pkg::status_t  status;
  krq_pkg::key_t     found_key;
  krq_pkg::handle_t  found_handle;
  krq_pkg::cnt_t     entry_count;

  modport source (output valid, output status, output found_key,
                  output found_handle, output entry_count, input ready);
  modport sink   (input valid, input status, input found_key,
                  input found_handle, input entry_count, output ready);
endinterface

### rtl/krq_store.sv
// ----------------------------------------------------------------------------
// krq_store
// Entry memory with one write and one registered read port, plus key compare.
// ----------------------------------------------------------------------------
module krq_store (
  input  logic                clk,
  input  krq_pkg::store_req_t req,
  input  krq_pkg::key_t       cmp_key,
  output krq_pkg::entry_t     rd_entry,
  output logic                hit
);
  import krq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_entry_r <= mem[req.rd_addr];
  end

  assign rd_entry = rd_entry_r;
  assign hit      = (rd_entry_r.key == cmp_key);

endmodule

### rtl/krq_ctrl.sv
// ----------------------------------------------------------------------------
// krq_ctrl
// Command sequencer: scans the queue one entry per cycle and closes gaps.
// ----------------------------------------------------------------------------
module krq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  krq_pkg::cmd_t       cmd_in,
  input  krq_pkg::key_t       key_in,
  input  krq_pkg::handle_t    handle_in,
  output logic                cmd_ready,
  input  logic                res_free,
  output logic                res_valid,
  output krq_pkg::result_t    res
);
  import krq_pkg::*;

  state_t     state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  key_t       key_r, key_nxt;
  handle_t    handle_r, handle_nxt;
  addr_t      idx_r, idx_nxt;
  cnt_t       count_r, count_nxt;
  status_t    status_r, status_nxt;
  key_t       rkey_r, rkey_nxt;
  handle_t    rhandle_r, rhandle_nxt;
  store_req_t req;
  entry_t     rd_entry;
  logic       hit;
  logic       take;
  cnt_t       idx_p1;
  cnt_t       idx_p2;
  logic       last;

  krq_store u_store (
    .clk      (clk),
    .req      (req),
    .cmp_key  (key_r),
    .rd_entry (rd_entry),
    .hit      (hit)
  );

  assign idx_p1 = cnt_t'(idx_r) + cnt_t'(1);
  assign idx_p2 = idx_p1 + cnt_t'(1);
  assign last   = (idx_p1 == count_r);
  assign take   = hit || (cmd_r == CMD_DEQUEUE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) state_nxt = S_START;
      end
      S_START: begin
        if (cmd_r == CMD_ENQUEUE || count_r == '0) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (take) begin
          if (cmd_r == CMD_SEARCH || last) state_nxt = S_DONE;
          else state_nxt = S_SHIFT;
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (idx_p2 == count_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    handle_nxt  = handle_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    rkey_nxt    = rkey_r;
    rhandle_nxt = rhandle_r;
    req.wr_en   = 1'b0;
    req.wr_addr = idx_r;
    req.wr_data = rd_entry;
    req.rd_addr = idx_p1[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        req.rd_addr = '0;
        if (cmd_valid) begin
          cmd_nxt    = cmd_in;
          key_nxt    = key_in;
          handle_nxt = handle_in;
        end
      end
      S_START: begin
        req.rd_addr = '0;
        idx_nxt     = '0;
        status_nxt  = ST_OK;
        rkey_nxt    = '0;
        rhandle_nxt = '0;
        if (cmd_r == CMD_ENQUEUE) begin
          if (count_r == cnt_t'(QUEUE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            req.wr_en   = 1'b1;
            req.wr_addr = count_r[ADDR_W-1:0];
            req.wr_data = '{key: key_r, handle: handle_r};
            count_nxt   = count_r + cnt_t'(1);
          end
        end else if (count_r == '0) begin
          status_nxt = (cmd_r == CMD_DEQUEUE) ? ST_EMPTY : ST_NOT_FOUND;
        end
      end
      S_SCAN: begin
        if (take) begin
          rkey_nxt    = rd_entry.key;
          rhandle_nxt = rd_entry.handle;
          if (cmd_r != CMD_SEARCH && last) count_nxt = count_r - cnt_t'(1);
        end else if (last) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          idx_nxt = idx_p1[ADDR_W-1:0];
        end
      end
      S_SHIFT: begin
        req.wr_en   = 1'b1;
        req.rd_addr = idx_p2[ADDR_W-1:0];
        idx_nxt     = idx_p1[ADDR_W-1:0];
        if (idx_p2 == count_r) count_nxt = count_r - cnt_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    handle_r  <= handle_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    rkey_r    <= rkey_nxt;
    rhandle_r <= rhandle_nxt;
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{status: status_r, key: rkey_r, handle: rhandle_r, count: count_r};

endmodule

### rtl/keyed_thread_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// keyed_thread_ready_queue_unit
// Ordered thread ready queue with enqueue, dequeue, keyed search and removal.
// ----------------------------------------------------------------------------
// One command is handled at a time. Dequeue, search and remove read and
// compare the entries in order, and dequeue and remove then move the later
// entries down, all through the single read port of the entry memory, one
// entry per cycle; enqueue and commands on an empty queue need no scan.
// A new command is accepted from the cycle after the previous one has reached
// the output register, so a stalled result does not hold up the next
// command's work.
module keyed_thread_ready_queue_unit (
  input  logic       clk,
  input  logic       rst_n,
  krq_in_if.sink     in_ch,
  krq_out_if.source  out_ch
);
  import krq_pkg::*;

  logic    res_valid;
  logic    res_free;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  krq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_ch.valid),
    .cmd_in    (in_ch.command),
    .key_in    (in_ch.thread_key),
    .handle_in (in_ch.thread_handle),
    .cmd_ready (in_ch.ready),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.found_key    = out_res_r.key;
  assign out_ch.found_handle = out_res_r.handle;
  assign out_ch.entry_count  = out_res_r.count;

endmodule
